FILE: rtl/scs_pkg.sv
// Shared types and codes for the script comment stripper.
`timescale 1ns / 1ps

package scs_pkg;

    localparam int SLOTS = 3;

    localparam logic [1:0] KIND_CODE  = 2'd0;
    localparam logic [1:0] KIND_TEXT  = 2'd1;
    localparam logic [1:0] KIND_CLOSE = 2'd2;

    localparam logic CK_LINE  = 1'b0;
    localparam logic CK_BLOCK = 1'b1;

    typedef struct packed {
        logic [7:0] ch;
        logic [1:0] kind;
        logic       ck;
    } scs_rec_t;

    typedef struct packed {
        logic [1:0] cnt;
        logic       last;
    } scs_ctl_t;

    localparam int REC_W = $bits(scs_rec_t);

endpackage

FILE: rtl/scs_front.sv
// Front scanner: accepts source bytes, tracks strings and comments, builds result groups.
`timescale 1ns / 1ps

module scs_front #(
    parameter int LINE_BITS = 24
) (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  logic                                         cfg_we,
    input  logic                                         collect_comments,
    input  logic                                         in_valid,
    input  logic [7:0]                                   in_char,
    input  logic                                         in_last,
    input  logic                                         queue_full,
    output logic                                         push,
    output scs_pkg::scs_ctl_t                            push_ctl,
    output logic [scs_pkg::SLOTS*(scs_pkg::REC_W+LINE_BITS)-1:0] push_data
);
    import scs_pkg::*;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'd0,
        MODE_STRING = 3'd1,
        MODE_STRESC = 3'd2,
        MODE_LINE   = 3'd3,
        MODE_BLOCK  = 3'd4
    } mode_t;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BT    = 8'h60;

    localparam logic [1:0] QUOTE_DQ = 2'd0;
    localparam logic [1:0] QUOTE_SQ = 2'd1;
    localparam logic [1:0] QUOTE_BT = 2'd2;

    localparam logic [LINE_BITS-1:0] LINE_ONE = LINE_BITS'(1);
    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    function automatic logic [7:0] quote_byte(input logic [1:0] q);
        logic [7:0] r;
        case (q)
            QUOTE_DQ: r = CH_DQ;
            QUOTE_SQ: r = CH_SQ;
            QUOTE_BT: r = CH_BT;
            default:  r = 8'h00;
        endcase
        return r;
    endfunction

    mode_t                mode_reg, mode_next;
    logic [1:0]           quote_reg, quote_next;
    logic                 held_reg, held_next;
    logic [LINE_BITS-1:0] line_reg, line_next;
    logic [LINE_BITS-1:0] csl_reg, csl_next;
    logic                 collect_reg;

    logic                 accept;
    logic [1:0]           n;
    logic                 do_normal;
    logic                 do_block;
    logic                 inc;
    logic                 ck;
    logic                 is_nl;
    scs_rec_t             rec [SLOTS];
    logic [LINE_BITS-1:0] rec_line [SLOTS];

    assign accept = in_valid && !queue_full;
    assign is_nl  = (in_char == CH_NL);

    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        line_next  = line_reg;
        csl_next   = csl_reg;
        n          = 2'd0;
        do_normal  = 1'b0;
        do_block   = 1'b0;
        inc        = 1'b0;
        ck         = CK_LINE;
        for (int i = 0; i < SLOTS; i++)
        begin
            rec[i]      = '0;
            rec_line[i] = '0;
        end

        unique case (mode_reg)
            MODE_NORMAL:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (in_char == CH_SLASH || in_char == CH_STAR)
                    begin
                        ck        = (in_char == CH_STAR) ? CK_BLOCK : CK_LINE;
                        csl_next  = line_reg;
                        mode_next = ck ? MODE_BLOCK : MODE_LINE;
                        if (!collect_reg)
                        begin
                            rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                            rec_line[n] = line_reg;
                            n = n + 2'd1;
                            rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                            rec_line[n] = line_reg;
                            n = n + 2'd1;
                        end
                        else if (in_last)
                        begin
                            rec[n] = '{ch: 8'h00, kind: KIND_CLOSE, ck: ck};
                            rec_line[n] = line_reg;
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        rec[n] = '{ch: CH_SLASH, kind: KIND_CODE, ck: CK_LINE};
                        rec_line[n] = line_reg;
                        n = n + 2'd1;
                        do_normal = 1'b1;
                    end
                end
                else
                begin
                    do_normal = 1'b1;
                end
            end
            MODE_STRING:
            begin
                rec[n] = '{ch: in_char, kind: KIND_CODE, ck: CK_LINE};
                rec_line[n] = line_reg;
                n = n + 2'd1;
                if (in_char == quote_byte(quote_reg))
                    mode_next = MODE_NORMAL;
                else if (in_char == CH_BSL && !in_last)
                    mode_next = MODE_STRESC;
                else if (is_nl)
                    inc = 1'b1;
            end
            MODE_STRESC:
            begin
                rec[n] = '{ch: in_char, kind: KIND_CODE, ck: CK_LINE};
                rec_line[n] = line_reg;
                n = n + 2'd1;
                inc = is_nl;
                mode_next = MODE_STRING;
            end
            MODE_LINE:
            begin
                if (is_nl)
                begin
                    if (collect_reg)
                    begin
                        rec[n] = '{ch: 8'h00, kind: KIND_CLOSE, ck: CK_LINE};
                        rec_line[n] = csl_reg;
                        n = n + 2'd1;
                    end
                    rec[n] = '{ch: CH_NL, kind: KIND_CODE, ck: CK_LINE};
                    rec_line[n] = line_reg;
                    n = n + 2'd1;
                    inc = 1'b1;
                    mode_next = MODE_NORMAL;
                end
                else
                begin
                    if (collect_reg)
                    begin
                        rec[n] = '{ch: in_char, kind: KIND_TEXT, ck: CK_LINE};
                        rec_line[n] = csl_reg;
                        n = n + 2'd1;
                        if (in_last)
                        begin
                            rec[n] = '{ch: 8'h00, kind: KIND_CLOSE, ck: CK_LINE};
                            rec_line[n] = csl_reg;
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                        rec_line[n] = line_reg;
                        n = n + 2'd1;
                    end
                end
            end
            MODE_BLOCK:
            begin
                if (held_reg)
                begin
                    held_next = 1'b0;
                    if (in_char == CH_SLASH)
                    begin
                        mode_next = MODE_NORMAL;
                        if (collect_reg)
                        begin
                            rec[n] = '{ch: 8'h00, kind: KIND_CLOSE, ck: CK_BLOCK};
                            rec_line[n] = csl_reg;
                            n = n + 2'd1;
                        end
                        else
                        begin
                            rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                            rec_line[n] = line_reg;
                            n = n + 2'd1;
                            rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                            rec_line[n] = line_reg;
                            n = n + 2'd1;
                        end
                    end
                    else
                    begin
                        if (collect_reg)
                        begin
                            rec[n] = '{ch: CH_STAR, kind: KIND_TEXT, ck: CK_BLOCK};
                            rec_line[n] = csl_reg;
                        end
                        else
                        begin
                            rec[n] = '{ch: CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                            rec_line[n] = line_reg;
                        end
                        n = n + 2'd1;
                        do_block = 1'b1;
                    end
                end
                else
                begin
                    do_block = 1'b1;
                end
            end
            default:
            begin
                mode_next = MODE_NORMAL;
                held_next = 1'b0;
                do_normal = 1'b1;
            end
        endcase

        if (do_block)
        begin
            if (in_last)
            begin
                if (collect_reg)
                begin
                    rec[n] = '{ch: 8'h00, kind: KIND_CLOSE, ck: CK_BLOCK};
                    rec_line[n] = csl_reg;
                    n = n + 2'd1;
                end
                rec[n] = '{ch: in_char, kind: KIND_CODE, ck: CK_LINE};
                rec_line[n] = line_reg;
                n = n + 2'd1;
                inc = is_nl;
                mode_next = MODE_NORMAL;
            end
            else if (in_char == CH_STAR)
            begin
                held_next = 1'b1;
            end
            else
            begin
                if (collect_reg)
                begin
                    rec[n] = '{ch: in_char, kind: KIND_TEXT, ck: CK_BLOCK};
                    rec_line[n] = csl_reg;
                end
                else
                begin
                    rec[n] = '{ch: is_nl ? CH_NL : CH_SPACE, kind: KIND_CODE, ck: CK_LINE};
                    rec_line[n] = line_reg;
                end
                n = n + 2'd1;
                inc = is_nl;
            end
        end

        if (do_normal)
        begin
            if (in_char == CH_SLASH && !in_last)
            begin
                held_next = 1'b1;
            end
            else
            begin
                rec[n] = '{ch: in_char, kind: KIND_CODE, ck: CK_LINE};
                rec_line[n] = line_reg;
                n = n + 2'd1;
                if (is_nl)
                begin
                    inc = 1'b1;
                end
                else if (in_char == CH_DQ || in_char == CH_SQ || in_char == CH_BT)
                begin
                    quote_next = (in_char == CH_DQ) ? QUOTE_DQ :
                                 (in_char == CH_SQ) ? QUOTE_SQ : QUOTE_BT;
                    mode_next  = MODE_STRING;
                end
            end
        end

        if (inc && line_reg != LINE_MAX)
            line_next = line_reg + LINE_ONE;

        if (in_last)
        begin
            mode_next  = MODE_NORMAL;
            quote_next = QUOTE_DQ;
            held_next  = 1'b0;
            line_next  = LINE_ONE;
            csl_next   = LINE_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_NORMAL;
            quote_reg   <= QUOTE_DQ;
            held_reg    <= 1'b0;
            line_reg    <= LINE_ONE;
            csl_reg     <= LINE_ONE;
            collect_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                collect_reg <= collect_comments;
            if (accept)
            begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                held_reg  <= held_next;
                line_reg  <= line_next;
                csl_reg   <= csl_next;
            end
        end
    end

    assign push          = accept && (n != 2'd0);
    assign push_ctl.cnt  = n;
    assign push_ctl.last = in_last;
    assign push_data     = {rec_line[2], rec_line[1], rec_line[0], rec[2], rec[1], rec[0]};

endmodule

FILE: rtl/scs_queue.sv
// Short queue of result groups between the scanner and the output stage.
`timescale 1ns / 1ps

module scs_queue #(
    parameter int WIDTH = 105,
    parameter int DEPTH = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  scs_pkg::scs_ctl_t push_ctl,
    input  logic [WIDTH-1:0]  push_data,
    input  logic              pop,
    output logic              full,
    output logic              empty,
    output scs_pkg::scs_ctl_t pop_ctl,
    output logic [WIDTH-1:0]  pop_data
);
    import scs_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);
    localparam logic [AW:0]   CNT_FULL = (AW + 1)'(DEPTH);

    scs_ctl_t         ctl_mem [DEPTH];
    logic [WIDTH-1:0] data_mem [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [AW:0]      count_reg, count_next;

    assign full     = (count_reg == CNT_FULL);
    assign empty    = (count_reg == '0);
    assign pop_ctl  = ctl_mem[rd_ptr_reg];
    assign pop_data = data_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ctl_mem[wr_ptr_reg]  <= push_ctl;
            data_mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/scs_back.sv
// Output stage: holds one result group and hands out its results one beat at a time.
`timescale 1ns / 1ps

module scs_back #(
    parameter int LINE_BITS = 24
) (
    input  logic                                                  clk,
    input  logic                                                  rst_n,
    input  logic                                                  empty,
    input  scs_pkg::scs_ctl_t                                     pop_ctl,
    input  logic [scs_pkg::SLOTS*(scs_pkg::REC_W+LINE_BITS)-1:0] pop_data,
    output logic                                                  pop,
    output logic                                                  out_valid,
    input  logic                                                  out_stall,
    output logic [7:0]                                            out_char,
    output logic [1:0]                                            kind,
    output logic                                                  comment_kind,
    output logic [LINE_BITS-1:0]                                  line_no,
    output logic                                                  out_last
);
    import scs_pkg::*;

    localparam int DW = SLOTS * (REC_W + LINE_BITS);

    logic            valid_reg, valid_next;
    scs_ctl_t        ctl_reg, ctl_next;
    logic [1:0]      idx_reg, idx_next;
    logic [DW-1:0]   data_reg;
    logic            fire;
    logic            last_slot;
    scs_rec_t        rec_sel;

    assign fire      = valid_reg && !out_stall;
    assign last_slot = (idx_reg == ctl_reg.cnt - 2'd1);
    assign pop       = !empty && (!valid_reg || (fire && last_slot));

    always_comb
    begin
        valid_next = valid_reg;
        ctl_next   = ctl_reg;
        idx_next   = idx_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            ctl_next   = pop_ctl;
            idx_next   = 2'd0;
        end
        else if (fire && last_slot)
        begin
            valid_next = 1'b0;
        end
        else if (fire)
        begin
            idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            ctl_reg   <= '0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            ctl_reg   <= ctl_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
            data_reg <= pop_data;
    end

    assign rec_sel      = data_reg[idx_reg * REC_W +: REC_W];
    assign out_valid    = valid_reg;
    assign out_char     = rec_sel.ch;
    assign kind         = rec_sel.kind;
    assign comment_kind = rec_sel.ck;
    assign line_no      = data_reg[SLOTS * REC_W + idx_reg * LINE_BITS +: LINE_BITS];
    assign out_last     = ctl_reg.last && last_slot;

endmodule

FILE: rtl/script_comment_stripper_core.sv
// Top level of the script comment stripper: scanner, group queue and output stage.
//
//  Channel   Direction  Handshake             Payload
//  input     in         in_valid / in_stall   in_char, in_last
//  output    out        out_valid / out_stall out_char, kind, comment_kind, line_no, out_last
//  config    in         cfg_we                collect_comments
//
// The scanner takes one byte per cycle while the group queue has room; its state
// machine settles each byte in that cycle. A byte gives up to three result beats,
// which the output stage hands out one per cycle unless out_stall is high, so with at
// most one beat per byte and no stall the rate is one byte per cycle. Beats pass the
// queue, then the output register. Reset clears all control state; no clearing pass is
// needed. Each side stalls on its own, the queue absorbing bursts of multi-beat groups.
`timescale 1ns / 1ps

module script_comment_stripper_core #(
    parameter int LINE_BITS   = 24,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic                 collect_comments,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           in_char,
    input  logic                 in_last,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [7:0]           out_char,
    output logic [1:0]           kind,
    output logic                 comment_kind,
    output logic [LINE_BITS-1:0] line_no,
    output logic                 out_last
);
    import scs_pkg::*;

    localparam int DW = SLOTS * (REC_W + LINE_BITS);

    logic          q_push;
    logic          q_pop;
    logic          q_full;
    logic          q_empty;
    scs_ctl_t      push_ctl;
    scs_ctl_t      pop_ctl;
    logic [DW-1:0] push_data;
    logic [DW-1:0] pop_data;

    assign in_stall = q_full;

    scs_front #(
        .LINE_BITS (LINE_BITS)
    ) u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .collect_comments (collect_comments),
        .in_valid         (in_valid),
        .in_char          (in_char),
        .in_last          (in_last),
        .queue_full       (q_full),
        .push             (q_push),
        .push_ctl         (push_ctl),
        .push_data        (push_data)
    );

    scs_queue #(
        .WIDTH (DW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_ctl  (push_ctl),
        .push_data (push_data),
        .pop       (q_pop),
        .full      (q_full),
        .empty     (q_empty),
        .pop_ctl   (pop_ctl),
        .pop_data  (pop_data)
    );

    scs_back #(
        .LINE_BITS (LINE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .empty        (q_empty),
        .pop_ctl      (pop_ctl),
        .pop_data     (pop_data),
        .pop          (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .kind         (kind),
        .comment_kind (comment_kind),
        .line_no      (line_no),
        .out_last     (out_last)
    );

    // The queue is never written while full, nor read while empty.
    assert property (@(posedge clk) disable iff (!rst_n) !(q_push && q_full))
        else $error("group queue written while full");

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> !q_empty)
        else $error("group queue read while empty");

    // Code beats never carry the block comment mark, and no unused kind code is given.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (kind == KIND_CODE || kind == KIND_TEXT || kind == KIND_CLOSE) &&
                      !(kind == KIND_CODE && comment_kind == CK_BLOCK))
        else $error("malformed output beat");

    // A closed record carries no byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind == KIND_CLOSE |-> out_char == 8'h00)
        else $error("record close beat carries a byte");

endmodule

FILE: bench/script_comment_stripper_core_tb.sv
// Self-checking testbench for the script comment stripper core, with a scoreboard class.
`timescale 1ns / 1ps

module script_comment_stripper_core_tb;

    import scs_pkg::*;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_BTICK = 8'h60;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef enum logic [2:0] {
        SCAN_CODE,
        SCAN_STRING,
        SCAN_ESCAPE,
        SCAN_LINE_CMT,
        SCAN_BLOCK_CMT
    } scan_mode_t;

    typedef struct {
        logic [7:0]  ch;
        logic [1:0]  kind;
        logic        ck;
        logic [23:0] line_no;
        logic        fin;
    } beat_t;

    class comment_scoreboard_t;
        beat_t       expected_q[$];
        beat_t       step_q[$];
        logic        collect;
        scan_mode_t  mode;
        logic [7:0]  quote_ch;
        logic        held;
        logic [23:0] line_cnt;
        logic [23:0] cmt_line;
        int          errors;

        function new();
            errors = 0;
            collect = 1'b0;
            clear_text();
        endfunction

        function void clear_text();
            mode = SCAN_CODE;
            quote_ch = CH_DQ;
            held = 1'b0;
            line_cnt = 24'd1;
            cmt_line = 24'd1;
        endfunction

        function void set_collect(logic v);
            collect = v;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void give(logic [7:0] c, logic [1:0] k, logic ck, logic [23:0] ln);
            beat_t b;
            if (step_q.size() >= SLOTS)
                return;
            b.ch = c;
            b.kind = k;
            b.ck = ck;
            b.line_no = ln;
            b.fin = 1'b0;
            step_q.insert(step_q.size(), b);
        endfunction

        function void give_code(logic [7:0] c);
            give(c, KIND_CODE, CK_LINE, line_cnt);
        endfunction

        function void close_rec(logic ck);
            give(8'h00, KIND_CLOSE, ck, cmt_line);
        endfunction

        function void bump_line();
            if (line_cnt != 24'hFFFFFF)
                line_cnt = line_cnt + 24'd1;
        endfunction

        function void plain_byte(logic [7:0] c, bit last);
            if (c == CH_SLASH && !last)
            begin
                held = 1'b1;
                return;
            end
            give_code(c);
            if (c == CH_NL)
                bump_line();
            else if (c == CH_DQ || c == CH_SQ || c == CH_BTICK)
            begin
                quote_ch = c;
                mode = SCAN_STRING;
            end
        endfunction

        function void block_text_byte(logic [7:0] c);
            if (collect)
                give(c, KIND_TEXT, CK_BLOCK, cmt_line);
            else
                give_code((c == CH_NL) ? CH_NL : CH_SPACE);
            if (c == CH_NL)
                bump_line();
        endfunction

        function void block_tail(logic [7:0] c, bit last);
            if (last)
            begin
                if (collect)
                    close_rec(CK_BLOCK);
                give_code(c);
                if (c == CH_NL)
                    bump_line();
                mode = SCAN_CODE;
            end
            else if (c == CH_STAR)
                held = 1'b1;
            else
                block_text_byte(c);
        endfunction

        function void note_byte(logic [7:0] c, bit last);
            logic ck;
            bit   done;
            step_q.delete();
            done = 1'b0;
            case (mode)
                SCAN_CODE:
                begin
                    if (held)
                    begin
                        held = 1'b0;
                        if (c == CH_SLASH || c == CH_STAR)
                        begin
                            ck = (c == CH_STAR) ? CK_BLOCK : CK_LINE;
                            cmt_line = line_cnt;
                            mode = (ck == CK_BLOCK) ? SCAN_BLOCK_CMT : SCAN_LINE_CMT;
                            if (!collect)
                            begin
                                give_code(CH_SPACE);
                                give_code(CH_SPACE);
                            end
                            else if (last)
                                close_rec(ck);
                        end
                        else
                        begin
                            give_code(CH_SLASH);
                            plain_byte(c, last);
                        end
                    end
                    else
                        plain_byte(c, last);
                end
                SCAN_STRING:
                begin
                    give_code(c);
                    if (c == quote_ch)
                        mode = SCAN_CODE;
                    else if (c == CH_BSL && !last)
                        mode = SCAN_ESCAPE;
                    else if (c == CH_NL)
                        bump_line();
                end
                SCAN_ESCAPE:
                begin
                    give_code(c);
                    if (c == CH_NL)
                        bump_line();
                    mode = SCAN_STRING;
                end
                SCAN_LINE_CMT:
                begin
                    if (c == CH_NL)
                    begin
                        if (collect)
                            close_rec(CK_LINE);
                        give_code(CH_NL);
                        bump_line();
                        mode = SCAN_CODE;
                    end
                    else
                    begin
                        if (collect)
                            give(c, KIND_TEXT, CK_LINE, cmt_line);
                        else
                            give_code(CH_SPACE);
                        if (last && collect)
                            close_rec(CK_LINE);
                    end
                end
                SCAN_BLOCK_CMT:
                begin
                    if (held)
                    begin
                        held = 1'b0;
                        if (c == CH_SLASH)
                        begin
                            mode = SCAN_CODE;
                            if (collect)
                                close_rec(CK_BLOCK);
                            else
                            begin
                                give_code(CH_SPACE);
                                give_code(CH_SPACE);
                            end
                            done = 1'b1;
                        end
                        else
                            block_text_byte(CH_STAR);
                    end
                    if (!done)
                        block_tail(c, last);
                end
                default:
                begin
                    mode = SCAN_CODE;
                    held = 1'b0;
                    plain_byte(c, last);
                end
            endcase
            if (last)
            begin
                if (step_q.size() > 0)
                    step_q[step_q.size() - 1].fin = 1'b1;
                clear_text();
            end
            foreach (step_q[i])
                expected_q.insert(expected_q.size(), step_q[i]);
        endfunction

        function void mismatch(string field, logic [23:0] e, logic [23:0] a);
            errors++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, e, a);
        endfunction

        function void check_beat(logic [7:0] c, logic [1:0] k, logic ck, logic [23:0] ln,
                                 logic fin);
            beat_t e;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat, expected none, actual char %h kind %h",
                         $time, c, k);
                return;
            end
            e = expected_q.pop_front();
            if (e.kind != KIND_CLOSE && c !== e.ch)
                mismatch("out_char", 24'(e.ch), 24'(c));
            if (k !== e.kind)
                mismatch("kind", 24'(e.kind), 24'(k));
            if (ck !== e.ck)
                mismatch("comment_kind", 24'(e.ck), 24'(ck));
            if (ln !== e.line_no)
                mismatch("line_no", e.line_no, ln);
            if (fin !== e.fin)
                mismatch("out_last", 24'(e.fin), 24'(fin));
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        collect_comments;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  in_char;
    logic        in_last;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_char;
    logic [1:0]  kind;
    logic        comment_kind;
    logic [23:0] line_no;
    logic        out_last;

    comment_scoreboard_t sb = new();
    logic [7:0] text_q[$];
    bit         no_idle = 1'b0;
    int         stall_left = 0;
    int         free_left = 0;

    script_comment_stripper_core #(
        .LINE_BITS(24)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .cfg_we(cfg_we),
        .collect_comments(collect_comments),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_char(in_char),
        .in_last(in_last),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_char(out_char),
        .kind(kind),
        .comment_kind(comment_kind),
        .line_no(line_no),
        .out_last(out_last)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(negedge clk)
    begin
        if (no_idle)
            out_stall <= 1'b0;
        else if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (free_left > 0)
        begin
            out_stall <= 1'b0;
            free_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            if ($urandom_range(0, 1) == 0)
                stall_left = $urandom_range(1, 16);
            else
                free_left = $urandom_range(1, 40);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_beat(out_char, kind, comment_kind, line_no, out_last);
    end

    function logic [7:0] letter();
        return 8'($urandom_range(97, 122));
    endfunction

    function logic [7:0] comment_byte();
        case ($urandom_range(0, 9))
            0, 1: return CH_STAR;
            2: return CH_SLASH;
            3: return CH_NL;
            4: return CH_DQ;
            5: return CH_BTICK;
            6: return 8'($urandom_range(0, 255));
            default: return letter();
        endcase
    endfunction

    function logic [7:0] quote_of(int n);
        case (n)
            0: return CH_DQ;
            1: return CH_SQ;
            default: return CH_BTICK;
        endcase
    endfunction

    function automatic void add_byte(logic [7:0] b);
        text_q.insert(text_q.size(), b);
    endfunction

    task automatic push_str(string s);
        foreach (s[i])
            add_byte(s[i]);
    endtask

    task automatic add_token();
        int         n;
        logic [7:0] q;
        case ($urandom_range(0, 9))
            0, 1:
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    add_byte(($urandom_range(0, 4) == 0) ? CH_SPACE : letter());
            end
            2: add_byte(CH_NL);
            3, 4:
            begin
                q = quote_of($urandom_range(0, 2));
                add_byte(q);
                n = $urandom_range(0, 6);
                repeat (n)
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            add_byte(CH_BSL);
                            add_byte(($urandom_range(0, 2) == 0) ? CH_NL : comment_byte());
                        end
                        1: add_byte(CH_NL);
                        2: add_byte(quote_of($urandom_range(0, 2)));
                        default: add_byte(letter());
                    endcase
                end
                if ($urandom_range(0, 7) != 0)
                    add_byte(q);
            end
            5, 6:
            begin
                add_byte(CH_SLASH);
                add_byte(CH_SLASH);
                n = $urandom_range(0, 8);
                repeat (n)
                    add_byte(comment_byte());
                if ($urandom_range(0, 3) != 0)
                    add_byte(CH_NL);
            end
            7, 8:
            begin
                add_byte(CH_SLASH);
                add_byte(CH_STAR);
                n = $urandom_range(0, 10);
                repeat (n)
                    add_byte(comment_byte());
                if ($urandom_range(0, 5) != 0)
                begin
                    if ($urandom_range(0, 2) == 0)
                        add_byte(CH_STAR);
                    add_byte(CH_STAR);
                    add_byte(CH_SLASH);
                end
            end
            default:
            begin
                n = $urandom_range(1, 3);
                repeat (n)
                begin
                    case ($urandom_range(0, 3))
                        0: add_byte(CH_SLASH);
                        1: add_byte(CH_STAR);
                        default: add_byte(8'($urandom_range(0, 255)));
                    endcase
                end
            end
        endcase
    endtask

    task automatic send_byte(logic [7:0] c, bit last, bit calm);
        int n;
        if (!no_idle && !calm && $urandom_range(0, 4) == 0)
        begin
            n = $urandom_range(1, 16);
            repeat (n)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_char <= c;
        in_last <= last;
        do
            @(posedge clk);
        while (in_stall);
        sb.note_byte(c, last);
    endtask

    task automatic send_text(bit mark_last, bit calm);
        foreach (text_q[i])
            send_byte(text_q[i], mark_last && (i == text_q.size() - 1), calm);
        text_q.delete();
    endtask

    task automatic drain();
        int spins;
        spins = 0;
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0 && spins < 200000)
        begin
            @(posedge clk);
            spins++;
        end
        repeat (8)
            @(posedge clk);
    endtask

    task automatic write_cfg(logic v);
        @(negedge clk);
        cfg_we <= 1'b1;
        collect_comments <= v;
        @(posedge clk);
        sb.set_collect(v);
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_phase(int budget, bit end_open);
        int sent;
        int target;
        bit calm;
        sent = 0;
        while (sent < budget)
        begin
            target = $urandom_range(1, 40);
            while (text_q.size() < target)
                add_token();
            calm = ($urandom_range(0, 3) == 0);
            sent += text_q.size();
            send_text(!(end_open && sent >= budget), calm);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        collect_comments = 1'b0;
        in_valid = 1'b0;
        in_char = 8'h00;
        in_last = 1'b0;
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;

        write_cfg(1'b1);
        push_str("x/*");
        add_byte(8'hFF);
        push_str("**///c\n'\\\n'/");
        send_text(1'b1, 1'b0);
        push_str("//");
        send_text(1'b1, 1'b0);
        push_str("/*a*");
        add_byte(8'h00);
        send_text(1'b1, 1'b0);
        push_str("//z");
        send_text(1'b1, 1'b0);
        drain();

        write_cfg(1'b0);
        push_str("/*");
        send_text(1'b1, 1'b0);
        add_byte(CH_DQ);
        add_byte(CH_BTICK);
        add_byte(CH_BSL);
        send_text(1'b1, 1'b0);
        drain();

        for (int p = 0; p < 6; p++)
        begin
            drain();
            write_cfg((p < 4) ? ((p % 2) == 0) : 1'($urandom_range(0, 1)));
            if (p == 5)
                no_idle = 1'b1;
            run_phase(45, (p != 5) && ($urandom_range(0, 1) == 1));
        end
        drain();
        repeat (10)
            @(posedge clk);

        if (sb.pending() != 0)
        begin
            sb.errors++;
            $display("%0t: expected %0d more result beats, actual 0", $time, sb.pending());
        end
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: sim.f
rtl/scs_pkg.sv
rtl/scs_front.sv
rtl/scs_queue.sv
rtl/scs_back.sv
rtl/script_comment_stripper_core.sv
bench/script_comment_stripper_core_tb.sv
